// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

    // Sizes of the byte stream and of the header length field
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;

    // Default depth of the queue between parser and checker
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // CRC-16/MODBUS constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_LSB  = 16'h0001;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] MAX_LEN_RST     = 16'd512;

    // Receive phase of the parser
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_LO  = 3'd4,
        PH_CRC_HI  = 3'd5
    } phase_t;

    // Work handed from parser to checker
    typedef enum logic [2:0] {
        CMD_HDR_FIRST = 3'd0,
        CMD_HDR       = 3'd1,
        CMD_PAY       = 3'd2,
        CMD_CRC_LO    = 3'd3,
        CMD_CRC_HI    = 3'd4
    } cmd_t;

    // Kind of a result item
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2
    } kind_t;

    // One queue entry: command, the byte and the header of its frame
    typedef struct packed {
        cmd_t               cmd;
        logic [BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]  version;
        logic [BYTE_W-1:0]  ftype;
        logic [BYTE_W-1:0]  seq;
        logic [LEN_W-1:0]   len;
    } q_entry_t;

    // Byte-wide CRC-16/MODBUS update, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_LSB) != 16'h0000)
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sfd_front.sv =====
module sfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 q_full,
    output logic                 q_push,
    output sfd_pkg::q_entry_t    q_wdata
);
    import sfd_pkg::*;

    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [LEN_W-1:0] max_len_reg;

    phase_t            phase_reg, phase_next;
    logic [2:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0] version_reg, version_next;
    logic [BYTE_W-1:0] ftype_reg, ftype_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [LEN_W-1:0]  full_len;
    logic [LEN_W-1:0]  byte_cnt_inc;
    logic              accept;

    assign s_tready     = !q_full;
    assign accept       = s_tvalid && s_tready;
    assign full_len     = {len_reg[15:8], s_tdata};
    assign byte_cnt_inc = byte_cnt_reg + 16'd1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_len_reg     <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata[7:0];
                CFG_MAX_LEN:     max_len_reg     <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            hdr_cnt_reg  <= 3'd0;
            version_reg  <= '0;
            ftype_reg    <= '0;
            seq_reg      <= '0;
            len_reg      <= '0;
            byte_cnt_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            version_reg  <= version_next;
            ftype_reg    <= ftype_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // Classify each byte and queue the work it needs
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        version_next  = version_reg;
        ftype_next    = ftype_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        byte_cnt_next = byte_cnt_reg;
        q_push        = 1'b0;
        q_wdata.cmd     = CMD_HDR;
        q_wdata.data    = s_tdata;
        q_wdata.version = version_reg;
        q_wdata.ftype   = ftype_reg;
        q_wdata.seq     = seq_reg;
        q_wdata.len     = len_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (s_tdata == sync_first_reg)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    // A repeated first sync byte keeps waiting
                    if (s_tdata == sync_second_reg)
                    begin
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = 3'd0;
                    end
                    else if (s_tdata != sync_first_reg)
                        phase_next = PH_SYNC1;
                end
                PH_HEADER:
                begin
                    q_push       = 1'b1;
                    q_wdata.cmd  = (hdr_cnt_reg == 3'd0) ? CMD_HDR_FIRST : CMD_HDR;
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    case (hdr_cnt_reg)
                        3'd0:    version_next = s_tdata;
                        3'd1:    ftype_next   = s_tdata;
                        3'd2:    seq_next     = s_tdata;
                        3'd3:    len_next     = {s_tdata, 8'h00};
                        default:
                        begin
                            hdr_cnt_next = 3'd0;
                            len_next     = full_len;
                            if (full_len > max_len_reg)
                            begin
                                // Drop an oversized frame silently
                                phase_next   = PH_SYNC1;
                                version_next = '0;
                                ftype_next   = '0;
                                seq_next     = '0;
                                len_next     = '0;
                            end
                            else
                            begin
                                byte_cnt_next = '0;
                                phase_next    = (full_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    q_push        = 1'b1;
                    q_wdata.cmd   = CMD_PAY;
                    byte_cnt_next = byte_cnt_inc;
                    if (byte_cnt_inc >= len_reg)
                        phase_next = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    q_push      = 1'b1;
                    q_wdata.cmd = CMD_CRC_LO;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    // Send the verdict request and clear the frame
                    q_push        = 1'b1;
                    q_wdata.cmd   = CMD_CRC_HI;
                    phase_next    = PH_SYNC1;
                    hdr_cnt_next  = 3'd0;
                    version_next  = '0;
                    ftype_next    = '0;
                    seq_next      = '0;
                    len_next      = '0;
                    byte_cnt_next = '0;
                end
                default:
                begin
                    phase_next    = PH_SYNC1;
                    hdr_cnt_next  = 3'd0;
                    version_next  = '0;
                    ftype_next    = '0;
                    seq_next      = '0;
                    len_next      = '0;
                    byte_cnt_next = '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sfd_queue.sv =====
module sfd_queue #(
    parameter int unsigned Depth = sfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfd_pkg::q_entry_t  wdata,
    output logic               full,
    input  logic               pop,
    output logic               rvalid,
    output sfd_pkg::q_entry_t  rdata
);
    import sfd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    q_entry_t          mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign rvalid  = (count_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/core/sfd_back.sv =====
module sfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sfd_pkg::q_entry_t  q_rdata,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);
    import sfd_pkg::*;

    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [BYTE_W-1:0] out_ver_reg;
    logic [BYTE_W-1:0] out_type_reg;
    logic [BYTE_W-1:0] out_seq_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg, out_last_next;
    logic              makes_item;
    logic              load_out;
    logic [15:0]       crc_got;

    assign makes_item = (q_rdata.cmd == CMD_PAY) || (q_rdata.cmd == CMD_CRC_HI);
    assign q_pop      = q_valid && (!makes_item || !out_valid_reg || m_tready);
    assign load_out   = q_pop && makes_item;
    assign crc_got    = {q_rdata.data, crc_lo_reg};

    // Run the CRC and build the result item
    always_comb
    begin
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        out_kind_next = KIND_PAYLOAD;
        out_data_next = q_rdata.data;
        out_last_next = 1'b0;
        if (q_pop)
        begin
            unique case (q_rdata.cmd)
                CMD_HDR_FIRST: crc_next = crc_byte(CRC_INIT, q_rdata.data);
                CMD_HDR:       crc_next = crc_byte(crc_reg, q_rdata.data);
                CMD_PAY:       crc_next = crc_byte(crc_reg, q_rdata.data);
                CMD_CRC_LO:    crc_lo_next = q_rdata.data;
                CMD_CRC_HI:
                begin
                    out_kind_next = (crc_got == crc_reg) ? KIND_GOOD : KIND_CRC_ERR;
                    out_data_next = '0;
                    out_last_next = 1'b1;
                    crc_next      = CRC_INIT;
                end
                default:       ;
            endcase
        end
    end

    // Hold the output until it is taken
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            crc_lo_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_ver_reg  <= q_rdata.version;
            out_type_reg <= q_rdata.ftype;
            out_seq_reg  <= q_rdata.seq;
            out_len_reg  <= q_rdata.len;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_seq_reg, out_type_reg, out_ver_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/sync_frame_deframer_crc16.sv =====
// Channel  | Dir | Signals                          | Contents
// ---------+-----+----------------------------------+----------------------------------
// s_       | in  | s_tvalid s_tready s_tdata[7:0]   | rx_byte
// m_       | out | m_tvalid m_tready m_tdata[47:0]  | data_byte, version, type, seq, len
//          |     | m_tuser[1:0] m_tlast             | item_kind, frame_last
// cfg_     | in  | cfg_we cfg_addr[1:0] cfg_wdata   | sync_first, sync_second, max len
//
// One byte is taken per cycle while the queue to the checker is not full; the byte-wide
// CRC update in the checker sets that rate. A payload byte or a verdict passes through
// the queue and then the checker's output register before it appears on the m_ side.
// The parser stalls only when the queue to the checker is full; the checker stalls
// only on m_tready. rst_n clears all control state at once, no clearing pass.
module sync_frame_deframer_crc16 #(
    parameter int unsigned QueueDepth = sfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] frame_version, [23:16] cmd_type,
    // [31:24] seq_num, [47:32] body_len
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser,    // [1:0] item_kind
    output logic        m_tlast
);
    import sfd_pkg::*;

    q_entry_t q_wdata;
    q_entry_t q_rdata;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;

    // Parse bytes and classify them
    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // Decouple parser from checker
    sfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // Run the CRC and emit results
    sfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/sfd_checker.sv =====
module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import sfd_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // A frame closes only with a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == KIND_GOOD) || (m_tuser == KIND_CRC_ERR))
        else $error("frame_last on a non-verdict item");

    // Every item without frame_last is a payload item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == KIND_PAYLOAD)
        else $error("verdict without frame_last");

    // Verdict items carry a zero data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
        else $error("nonzero data byte on verdict");

endmodule

bind sync_frame_deframer_crc16 sfd_checker u_sfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/tb.sv =====
module tb;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_BYTES  = 230;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One result of the deframer as it appears on the m_ side
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  ver;
        logic [7:0]  ftype;
        logic [7:0]  seq;
        logic [15:0] len;
        logic        last;
    } frame_item_t;

    // What a directed row puts on the line
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CRC_BAD
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic [7:0] val;
        bit         typed;
        kind_t      kind;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = CFG_SYNC_FIRST;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Register copies and parser state of the predictor
    logic [7:0]  cfg_sync_a;
    logic [7:0]  cfg_sync_b;
    logic [15:0] cfg_max_len;
    phase_t      cur_phase;
    logic [2:0]  hdr_idx;
    logic [7:0]  h_ver;
    logic [7:0]  h_type;
    logic [7:0]  h_seq;
    logic [15:0] h_len;
    logic [15:0] pay_count;
    logic [15:0] crc_run;
    logic [7:0]  crc_lo_b;

    frame_item_t frame_items_due [$];
    int unsigned err_count    = 0;
    int unsigned sent_bytes   = 0;
    int unsigned cycle_count  = 0;
    bit          hold_out_req = 1'b0;
    bit          calm_tail    = 1'b0;
    dir_row_t    dir_rows [30];

    sync_frame_deframer_crc16 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // CRC-16/MODBUS, one input bit at a time, LSB first
    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Return the parser to the hunt with all frame state cleared
    function automatic void reset_frame_state();
        cur_phase = PH_SYNC1;
        hdr_idx   = 3'd0;
        h_ver     = 8'h00;
        h_type    = 8'h00;
        h_seq     = 8'h00;
        h_len     = 16'h0000;
        pay_count = 16'h0000;
        crc_run   = CRC_INIT;
        crc_lo_b  = 8'h00;
    endfunction

    // Advance the parser by one received byte; return 1 when a result comes out
    function automatic bit deframe_byte(input logic [7:0] b, output frame_item_t it);
        bit got;
        got = 1'b0;
        it  = '0;
        case (cur_phase)
            PH_SYNC1:
            begin
                if (b == cfg_sync_a)
                    cur_phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (b == cfg_sync_b)
                begin
                    cur_phase = PH_HEADER;
                    hdr_idx   = 3'd0;
                    crc_run   = CRC_INIT;
                end
                else if (b != cfg_sync_a)
                    cur_phase = PH_SYNC1;
            end
            PH_HEADER:
            begin
                crc_run = crc16_modbus_next(crc_run, b);
                case (hdr_idx)
                    3'd0:    h_ver  = b;
                    3'd1:    h_type = b;
                    3'd2:    h_seq  = b;
                    3'd3:    h_len  = {b, 8'h00};
                    default: h_len  = h_len | {8'h00, b};
                endcase
                hdr_idx = hdr_idx + 3'd1;
                if (hdr_idx >= 3'd5)
                begin
                    hdr_idx = 3'd0;
                    if (h_len > cfg_max_len)
                        reset_frame_state();
                    else
                    begin
                        pay_count = 16'h0000;
                        if (h_len == 16'h0000)
                            cur_phase = PH_CRC_LO;
                        else
                            cur_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                crc_run   = crc16_modbus_next(crc_run, b);
                pay_count = pay_count + 16'd1;
                if (pay_count >= h_len)
                    cur_phase = PH_CRC_LO;
                it  = '{KIND_PAYLOAD, b, h_ver, h_type, h_seq, h_len, 1'b0};
                got = 1'b1;
            end
            PH_CRC_LO:
            begin
                crc_lo_b  = b;
                cur_phase = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                if ({b, crc_lo_b} == crc_run)
                    it = '{KIND_GOOD, 8'h00, h_ver, h_type, h_seq, h_len, 1'b1};
                else
                    it = '{KIND_CRC_ERR, 8'h00, h_ver, h_type, h_seq, h_len, 1'b1};
                got = 1'b1;
                reset_frame_state();
            end
            default:
                reset_frame_state();
        endcase
        return got;
    endfunction

    // Offer one byte, hold it until the transfer, then predict its result
    task automatic push_byte(input logic [7:0] b, input bit typed, input kind_t tkind);
        frame_item_t it;
        bit          got;
        if (!calm_tail && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_bytes++;
        got = deframe_byte(b, it);
        // Directed verdict rows carry their kind typed in the table
        if (typed)
        begin
            it.kind = tkind;
            it.data = 8'h00;
            it.last = 1'b1;
            got     = 1'b1;
        end
        if (got)
            frame_items_due.push_back(it);
    endtask

    // Stop sending, wait for every result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_items_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back
    task automatic cfg_apply(input logic [7:0] first, input logic [7:0] second,
                             input logic [15:0] max_len);
        cfg_sync_a  = first;
        cfg_sync_b  = second;
        cfg_max_len = max_len;
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SYNC_FIRST;
        cfg_wdata <= {8'h00, first};
        @(posedge clk);
        cfg_addr  <= CFG_SYNC_SECOND;
        cfg_wdata <= {8'h00, second};
        @(posedge clk);
        cfg_addr  <= CFG_MAX_LEN;
        cfg_wdata <= max_len;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build one frame (or a broken start) with random content and send it
    task automatic send_frame();
        logic [7:0]  fq [$];
        logic [15:0] flen;
        logic [15:0] crc;
        logic [7:0]  bv;
        int unsigned r;
        int unsigned reps;
        int unsigned t;
        int unsigned lim;
        int unsigned cap;
        repeat ($urandom_range(0, 3)) fq.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // first sync followed by an arbitrary byte
            fq.push_back(cfg_sync_a);
            fq.push_back(8'($urandom));
        end
        else
        begin
            reps = (r < 20) ? $urandom_range(2, 3) : 1;
            repeat (reps) fq.push_back(cfg_sync_a);
            fq.push_back(cfg_sync_b);
            if (r >= 20 && r < 30 && cfg_max_len != 16'hFFFF)
            begin
                // length above the limit: frame gets dropped
                if ($urandom_range(0, 3) == 0)
                    t = 32'hFFFF;
                else
                    t = 32'(cfg_max_len) + $urandom_range(1, 50);
                if (t > 32'hFFFF)
                    t = 32'hFFFF;
                flen = 16'(t);
            end
            else
            begin
                lim  = ($urandom_range(0, 19) == 0) ? 200 : 12;
                cap  = (32'(cfg_max_len) < lim) ? 32'(cfg_max_len) : lim;
                flen = 16'($urandom_range(0, cap));
            end
            crc = CRC_INIT;
            for (int i = 0; i < 5; i++)
            begin
                if (i == 3)
                    bv = flen[15:8];
                else if (i == 4)
                    bv = flen[7:0];
                else
                    bv = 8'($urandom);
                crc = crc16_modbus_next(crc, bv);
                fq.push_back(bv);
            end
            if (flen <= cfg_max_len)
            begin
                repeat (flen)
                begin
                    bv  = 8'($urandom);
                    crc = crc16_modbus_next(crc, bv);
                    fq.push_back(bv);
                end
                if ($urandom_range(0, 99) < 15)
                    crc = crc ^ 16'($urandom_range(1, 65535));
                fq.push_back(crc[7:0]);
                fq.push_back(crc[15:8]);
            end
        end
        foreach (fq[i])
            push_byte(fq[i], 1'b0, KIND_PAYLOAD);
    endtask

    // Receiver: short random stalls, one long hold-off on request
    initial
    begin : sink_ready
        forever
        begin
            @(posedge clk);
            if (hold_out_req)
            begin
                hold_out_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 99) < 12)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        frame_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_items_due.size() == 0)
            begin
                $error("unexpected result: item_kind %0d, data_byte 0x%02h",
                       m_tuser, m_tdata[7:0]);
                err_count++;
            end
            else
            begin
                want = frame_items_due.pop_front();
                if (m_tuser != want.kind)
                begin
                    $error("item_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    err_count++;
                end
                if (m_tdata[7:0] != want.data)
                begin
                    $error("data_byte: expected 0x%02h, actual 0x%02h",
                           want.data, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[15:8] != want.ver)
                begin
                    $error("frame_version: expected 0x%02h, actual 0x%02h",
                           want.ver, m_tdata[15:8]);
                    err_count++;
                end
                if (m_tdata[23:16] != want.ftype)
                begin
                    $error("cmd_type: expected 0x%02h, actual 0x%02h",
                           want.ftype, m_tdata[23:16]);
                    err_count++;
                end
                if (m_tdata[31:24] != want.seq)
                begin
                    $error("seq_num: expected 0x%02h, actual 0x%02h",
                           want.seq, m_tdata[31:24]);
                    err_count++;
                end
                if (m_tdata[47:32] != want.len)
                begin
                    $error("body_len: expected %0d, actual %0d",
                           want.len, m_tdata[47:32]);
                    err_count++;
                end
                if (m_tlast != want.last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  bv;
        int unsigned mark;

        cfg_sync_a  = SYNC_FIRST_RST;
        cfg_sync_b  = SYNC_SECOND_RST;
        cfg_max_len = MAX_LEN_RST;
        reset_frame_state();

        dir_rows = '{
            // zero length, repeated first sync, good CRC
            '{ROW_BYTE,    8'hAA, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'hAA, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h55, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'hFF, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h80, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_CRC_LO,  8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_CRC_HI,  8'h00, 1'b1, KIND_GOOD},
            // other byte in place of the second sync
            '{ROW_BYTE,    8'hAA, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h12, 1'b0, KIND_PAYLOAD},
            // length 513 is one above the limit: dropped
            '{ROW_BYTE,    8'hAA, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h55, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h01, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'hFF, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h7F, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h02, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h01, 1'b0, KIND_PAYLOAD},
            // two payload bytes, corrupted CRC
            '{ROW_BYTE,    8'hAA, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h55, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h01, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h02, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h02, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'hFF, 1'b0, KIND_PAYLOAD},
            '{ROW_BYTE,    8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_CRC_LO,  8'h00, 1'b0, KIND_PAYLOAD},
            '{ROW_CRC_BAD, 8'h00, 1'b1, KIND_CRC_ERR}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under the reset configuration
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].op)
                ROW_CRC_LO:  bv = crc_run[7:0];
                ROW_CRC_HI:  bv = crc_run[15:8];
                ROW_CRC_BAD: bv = ~crc_run[15:8];
                default:     bv = dir_rows[i].val;
            endcase
            push_byte(bv, dir_rows[i].typed, dir_rows[i].kind);
        end
        drain();

        // Random frames under a series of register settings
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: cfg_apply(8'h00, 8'hFF, 16'h0000);
                1: cfg_apply(8'hFF, 8'h00, 16'hFFFF);
                2: cfg_apply(8'h5A, 8'h5A, 16'd8);
                3: cfg_apply(8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)));
                default: cfg_apply(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST);
            endcase
            if (p == 1)
                hold_out_req = 1'b1;
            if (p == 4)
                calm_tail = 1'b1;
            mark = sent_bytes;
            while (sent_bytes - mark < PHASE_BYTES)
                send_frame();
            drain();
        end

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sfd_pkg.sv
rtl/core/sfd_front.sv
rtl/core/sfd_queue.sv
rtl/core/sfd_back.sv
rtl/core/sync_frame_deframer_crc16.sv
rtl/core/sfd_checker.sv
sim/tb.sv
